// ===== rtl/skt_pkg.sv =====
// shared types, constants and codes for the sorted key table
package skt_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int KEY_W = 32;
  localparam int PAY_W = 64;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_LOOKUP = 3'd1,
    OP_UPDATE = 3'd2,
    OP_DELETE = 3'd3,
    OP_LIST   = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_PUT,
    S_FIND,
    S_DEL,
    S_LIST
  } state_t;

  typedef struct packed {
    opcode_t                  opcode;
    logic signed [KEY_W-1:0]  key;
    logic        [PAY_W-1:0]  payload;
  } in_item_t;

  typedef struct packed {
    status_t                  status;
    logic signed [KEY_W-1:0]  entry_key;
    logic        [PAY_W-1:0]  entry_payload;
    logic                     last;
  } out_item_t;

  typedef struct packed {
    logic signed [KEY_W-1:0]  key;
    logic        [PAY_W-1:0]  payload;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } emit_t;

endpackage

// ===== rtl/skt_ram.sv =====
// generic single-write, single-read ram with registered read data
module skt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/skt_ctrl.sv =====
// sequencer that walks the entry ram for insert, search, delete and list
module skt_ctrl
  import skt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  in_item_t in_item,
  input  entry_t   rd_entry,
  output logic     busy,
  output mem_req_t req,
  output emit_t    emit
);

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] walk_r, walk_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  in_item_t         cmd_r, cmd_nxt;

  logic full, empty, at_last, greater, hit;
  logic [IDX_W-1:0] top_idx;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign top_idx = IDX_W'(count_r - CNT_W'(1));
  assign at_last = ((CNT_W'(walk_r) + CNT_W'(1)) == count_r);
  assign greater = (rd_entry.key > cmd_r.key);
  assign hit     = (rd_entry.key == cmd_r.key);
  assign busy    = (state_r != S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_item.opcode) inside
            OP_INSERT: begin
              if (!full && !empty) state_nxt = S_INS;
              else if (!full)      state_nxt = S_PUT;
            end
            OP_LOOKUP, OP_UPDATE, OP_DELETE: begin
              if (!empty) state_nxt = S_FIND;
            end
            OP_LIST: begin
              if (!empty) state_nxt = S_LIST;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_INS: begin
        if (!greater)            state_nxt = S_IDLE;
        else if (walk_r == '0)   state_nxt = S_PUT;
      end
      S_PUT: state_nxt = S_IDLE;
      S_FIND: begin
        if (hit) begin
          state_nxt = (cmd_r.opcode == OP_DELETE && !at_last) ? S_DEL : S_IDLE;
        end else if (at_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_DEL:  if (at_last) state_nxt = S_IDLE;
      S_LIST: if (at_last) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    req       = '0;
    emit      = '0;
    walk_nxt  = walk_r;
    count_nxt = count_r;
    cmd_nxt   = cmd_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt = in_item;
          case (in_item.opcode) inside
            OP_INSERT: begin
              if (full) begin
                emit.valid = 1'b1;
                emit.item  = '{ST_FULL, in_item.key, in_item.payload, 1'b1};
              end else if (!empty) begin
                // walk down from the top entry
                req.re    = 1'b1;
                req.raddr = top_idx;
                walk_nxt  = top_idx;
              end else begin
                walk_nxt = '0;
              end
            end
            OP_LOOKUP, OP_UPDATE, OP_DELETE: begin
              if (empty) begin
                emit.valid = 1'b1;
                emit.item  = '{ST_NOT_FOUND, in_item.key, '0, 1'b1};
              end else begin
                req.re    = 1'b1;
                req.raddr = '0;
                walk_nxt  = '0;
              end
            end
            OP_LIST: begin
              if (empty) begin
                emit.valid = 1'b1;
                emit.item  = '{ST_NOT_FOUND, '0, '0, 1'b1};
              end else begin
                req.re    = 1'b1;
                req.raddr = '0;
                walk_nxt  = '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_INS: begin
        req.we    = 1'b1;
        req.waddr = walk_r + IDX_W'(1);
        if (greater) begin
          // move this entry up one slot, keep walking down
          req.wdata = rd_entry;
          if (walk_r != '0) begin
            req.re    = 1'b1;
            req.raddr = walk_r - IDX_W'(1);
            walk_nxt  = walk_r - IDX_W'(1);
          end
        end else begin
          req.wdata  = '{cmd_r.key, cmd_r.payload};
          emit.valid = 1'b1;
          emit.item  = '{ST_OK, cmd_r.key, cmd_r.payload, 1'b1};
          count_nxt  = count_r + CNT_W'(1);
        end
      end
      S_PUT: begin
        req.we     = 1'b1;
        req.waddr  = walk_r;
        req.wdata  = '{cmd_r.key, cmd_r.payload};
        emit.valid = 1'b1;
        emit.item  = '{ST_OK, cmd_r.key, cmd_r.payload, 1'b1};
        count_nxt  = count_r + CNT_W'(1);
      end
      S_FIND: begin
        if (hit) begin
          emit.valid = 1'b1;
          emit.item  = '{ST_OK, rd_entry.key, rd_entry.payload, 1'b1};
          if (cmd_r.opcode == OP_UPDATE) begin
            req.we                  = 1'b1;
            req.waddr               = walk_r;
            req.wdata               = '{rd_entry.key, cmd_r.payload};
            emit.item.entry_payload = cmd_r.payload;
          end else if (cmd_r.opcode == OP_DELETE) begin
            if (at_last) begin
              count_nxt = count_r - CNT_W'(1);
            end else begin
              req.re    = 1'b1;
              req.raddr = walk_r + IDX_W'(1);
              walk_nxt  = walk_r + IDX_W'(1);
            end
          end
        end else if (at_last) begin
          emit.valid = 1'b1;
          emit.item  = '{ST_NOT_FOUND, cmd_r.key, '0, 1'b1};
        end else begin
          req.re    = 1'b1;
          req.raddr = walk_r + IDX_W'(1);
          walk_nxt  = walk_r + IDX_W'(1);
        end
      end
      S_DEL: begin
        req.we    = 1'b1;
        req.waddr = walk_r - IDX_W'(1);
        req.wdata = rd_entry;
        if (at_last) begin
          count_nxt = count_r - CNT_W'(1);
        end else begin
          req.re    = 1'b1;
          req.raddr = walk_r + IDX_W'(1);
          walk_nxt  = walk_r + IDX_W'(1);
        end
      end
      S_LIST: begin
        emit.valid = 1'b1;
        emit.item  = '{ST_OK, rd_entry.key, rd_entry.payload, at_last};
        if (!at_last) begin
          req.re    = 1'b1;
          req.raddr = walk_r + IDX_W'(1);
          walk_nxt  = walk_r + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    walk_r <= walk_nxt;
    cmd_r  <= cmd_nxt;
  end

endmodule

// ===== rtl/sorted_key_table.sv =====
// top level of the sorted key table: entry ram, sequencer and result register
//
//   channel  ports                       transfer
//   -------  --------------------------  -------------------------------
//   input    start, busy, in_item        start high while busy low
//   result   out_valid, out_item         out_valid high, one cycle each
//
// each operation walks the entry ram through its single read port, one
// entry per cycle; an insert that lands at entry 0 ends with a separate
// write step. insert walks down from the top entry, search and delete
// walk up from entry 0, list visits all. results are registered and appear
// in the cycle after the step that makes them; a list gives one result per
// cycle. reset clears the entry count, the sequencer state and the result
// strobe; the ram keeps its contents. there is no result back-pressure.
module sorted_key_table
  import skt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  mem_req_t  req;
  emit_t     emit;
  entry_t    rd_entry;
  logic      out_valid_r;
  out_item_t out_item_r;

  // entry storage: key and payload side by side, one entry per word
  skt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (req.we),
    .waddr (req.waddr),
    .wdata (req.wdata),
    .re    (req.re),
    .raddr (req.raddr),
    .rdata (rd_entry)
  );

  // walk sequencing, compare and shift decisions
  skt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_item  (in_item),
    .rd_entry (rd_entry),
    .busy     (busy),
    .req      (req),
    .emit     (emit)
  );

  // result register, one cycle strobe per transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit.valid;
    end
    out_item_r <= emit.item;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== rtl/skt_checker.sv =====
// port-level checks for the sorted key table, bound to the top level
module skt_checker
  import skt_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_item,
  input logic      out_valid,
  input out_item_t out_item
);

  // reset leaves no operation running and no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("busy or result after reset");

  // only ok list results can be followed by more
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != ST_OK) |-> out_item.last)
    else $error("error result without last");

  // a non-final result means the list walk is still running
  a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.last) |-> busy)
    else $error("non-final result while idle");

  // a valid operation either starts a walk or answers at once
  a_start_acts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.opcode == OP_INSERT || in_item.opcode == OP_LOOKUP ||
      in_item.opcode == OP_UPDATE || in_item.opcode == OP_DELETE ||
      in_item.opcode == OP_LIST)) |=> (busy || out_valid))
    else $error("accepted operation had no effect");

endmodule

bind sorted_key_table skt_checker u_skt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);
